// ===== hw/rtl/lvrf_pkg.sv =====
// ----------------------------------------------------------------------------
// lvrf_pkg
// Shared constants and types of the longest vertical run finder.
// ----------------------------------------------------------------------------
package lvrf_pkg;

    localparam int MAX_DIM_DEFAULT = 1024;

    // Width of a size register and of its write data.
    localparam int CFG_W = 11;
    localparam logic [CFG_W-1:0] SIZE_RESET = 11'd1024;

    // Register indexes of the configuration port.
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    // Width of the column and row fields of a result.
    localparam int OUT_POS_W = 10;

    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 32;

    // Control bits of one candidate run handed from the tracker to the selector.
    typedef struct packed {
        logic valid;
        logic offer;
        logic frame_end;
    } lvrf_cand_ctrl_t;

endpackage

// ===== hw/rtl/lvrf_column_store.sv =====
// ----------------------------------------------------------------------------
// lvrf_column_store
// Per-column run memory: one write and one registered read each cycle, with
// the write data forwarded when the read targets the entry being written.
// ----------------------------------------------------------------------------
module lvrf_column_store #(
    parameter int DEPTH = lvrf_pkg::MAX_DIM_DEFAULT,
    parameter int AW    = $clog2(DEPTH),
    parameter int DW    = AW + 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);
    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;
    logic [DW-1:0] fwd_data_reg;
    logic          fwd_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg  <= mem[rd_addr];
        fwd_data_reg <= wr_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_reg <= 1'b0;
        end else begin
            fwd_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    assign rd_data = fwd_reg ? fwd_data_reg : rd_data_reg;

endmodule

// ===== hw/rtl/lvrf_run_tracker.sv =====
// ----------------------------------------------------------------------------
// lvrf_run_tracker
// Raster counters and per-column run update; turns each accepted pixel into
// a store write and a registered candidate, offered where a run closes.
// ----------------------------------------------------------------------------
module lvrf_run_tracker #(
    parameter int MAX_DIM = lvrf_pkg::MAX_DIM_DEFAULT,
    parameter int CW      = $clog2(MAX_DIM),
    parameter int LW      = $clog2(MAX_DIM + 1)
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [lvrf_pkg::CFG_W-1:0]   image_width,
    input  logic [lvrf_pkg::CFG_W-1:0]   image_height,
    input  logic                         accept,
    input  logic                         advance,
    input  logic                         pixel,
    input  logic [CW:0]                  entry,
    output logic                         wr_en,
    output logic [CW-1:0]                wr_addr,
    output logic [CW:0]                  wr_data,
    output logic [CW-1:0]                rd_addr,
    output lvrf_pkg::lvrf_cand_ctrl_t    cand_ctrl,
    output logic [CW-1:0]                cand_col,
    output logic [CW-1:0]                cand_first,
    output logic [CW-1:0]                cand_last,
    output logic [LW-1:0]                cand_len
);
    import lvrf_pkg::*;

    localparam int EW = (CFG_W > LW) ? CFG_W : LW;

    logic [CW-1:0]   col_reg, col_next;
    logic [CW-1:0]   row_reg, row_next;
    logic [CW-1:0]   last_w, last_h;
    logic [EW-1:0]   width_ext, height_ext;
    logic            last_col, last_row;
    logic            open;
    logic [CW-1:0]   first, last;
    logic            offer;

    lvrf_cand_ctrl_t cand_ctrl_reg, cand_ctrl_next;
    logic [CW-1:0]   cand_col_reg, cand_first_reg, cand_last_reg;
    logic [LW-1:0]   cand_len_reg;

    always_comb begin
        width_ext  = EW'(image_width);
        height_ext = EW'(image_height);
        if (image_width == '0) begin
            last_w = '0;
        end else if (width_ext > EW'(MAX_DIM)) begin
            last_w = CW'(MAX_DIM - 1);
        end else begin
            last_w = CW'(width_ext - EW'(1));
        end
        if (image_height == '0) begin
            last_h = '0;
        end else if (height_ext > EW'(MAX_DIM)) begin
            last_h = CW'(MAX_DIM - 1);
        end else begin
            last_h = CW'(height_ext - EW'(1));
        end
    end

    always_comb begin
        last_col = col_reg >= last_w;
        last_row = row_reg >= last_h;
        open     = (row_reg != '0) && entry[CW];
        first    = open ? entry[CW-1:0] : row_reg;
        last     = pixel ? row_reg : (row_reg - CW'(1));
        offer    = pixel ? last_row : open;

        wr_en    = accept;
        wr_addr  = col_reg;
        wr_data  = (pixel && !last_row) ? {1'b1, first} : '0;

        col_next = col_reg;
        row_next = row_reg;
        if (accept) begin
            if (last_col) begin
                col_next = '0;
                row_next = last_row ? '0 : (row_reg + CW'(1));
            end else begin
                col_next = col_reg + CW'(1);
            end
        end
        rd_addr = col_next;

        cand_ctrl_next.valid     = accept;
        cand_ctrl_next.offer     = accept && offer;
        cand_ctrl_next.frame_end = accept && last_col && last_row;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg       <= '0;
            row_reg       <= '0;
            cand_ctrl_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (advance) begin
                cand_ctrl_reg <= cand_ctrl_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            cand_col_reg   <= col_reg;
            cand_first_reg <= first;
            cand_last_reg  <= last;
            cand_len_reg   <= LW'(last) - LW'(first) + LW'(1);
        end
    end

    assign cand_ctrl  = cand_ctrl_reg;
    assign cand_col   = cand_col_reg;
    assign cand_first = cand_first_reg;
    assign cand_last  = cand_last_reg;
    assign cand_len   = cand_len_reg;

endmodule

// ===== hw/rtl/lvrf_best_select.sv =====
// ----------------------------------------------------------------------------
// lvrf_best_select
// Keeps the best run of the frame and loads the result register at the end
// of each frame.
// ----------------------------------------------------------------------------
module lvrf_best_select #(
    parameter int MAX_DIM = lvrf_pkg::MAX_DIM_DEFAULT,
    parameter int CW      = $clog2(MAX_DIM),
    parameter int LW      = $clog2(MAX_DIM + 1)
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  lvrf_pkg::lvrf_cand_ctrl_t      cand_ctrl,
    input  logic [CW-1:0]                  cand_col,
    input  logic [CW-1:0]                  cand_first,
    input  logic [CW-1:0]                  cand_last,
    input  logic [LW-1:0]                  cand_len,
    output logic                           stall,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [lvrf_pkg::M_TDATA_W-1:0] m_tdata
);
    import lvrf_pkg::*;

    logic [LW-1:0]        best_len_reg, best_len_next;
    logic [CW-1:0]        best_first_reg, best_first_next;
    logic [CW-1:0]        best_col_reg, best_col_next;
    logic [CW-1:0]        best_end_reg, best_end_next;
    logic                 better, take, found;
    logic                 m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg, m_data_next;

    always_comb begin
        stall  = cand_ctrl.valid && cand_ctrl.frame_end && m_valid_reg && !m_tready;
        take   = cand_ctrl.valid && !stall;
        better = cand_ctrl.offer && ((cand_len > best_len_reg) ||
                 ((cand_len == best_len_reg) && ((cand_first < best_first_reg) ||
                 ((cand_first == best_first_reg) && (cand_col < best_col_reg)))));

        best_len_next   = best_len_reg;
        best_first_next = best_first_reg;
        best_col_next   = best_col_reg;
        best_end_next   = best_end_reg;
        if (better) begin
            best_len_next   = cand_len;
            best_first_next = cand_first;
            best_col_next   = cand_col;
            best_end_next   = cand_last;
        end

        found       = best_len_next != '0;
        m_data_next = '0;
        if (found) begin
            m_data_next[0]                 = 1'b1;
            m_data_next[OUT_POS_W:1]       = OUT_POS_W'(best_col_next);
            m_data_next[2*OUT_POS_W:OUT_POS_W+1]     = OUT_POS_W'(best_first_next);
            m_data_next[3*OUT_POS_W:2*OUT_POS_W+1]   = OUT_POS_W'(best_end_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_len_reg   <= '0;
            best_first_reg <= '0;
            best_col_reg   <= '0;
            best_end_reg   <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (take) begin
                if (cand_ctrl.frame_end) begin
                    best_len_reg   <= '0;
                    best_first_reg <= '0;
                    best_col_reg   <= '0;
                    best_end_reg   <= '0;
                    m_valid_reg    <= 1'b1;
                end else begin
                    best_len_reg   <= best_len_next;
                    best_first_reg <= best_first_next;
                    best_col_reg   <= best_col_next;
                    best_end_reg   <= best_end_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take && cand_ctrl.frame_end) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// ===== hw/rtl/longest_vertical_run_finder.sv =====
// ----------------------------------------------------------------------------
// longest_vertical_run_finder
// Finds the longest vertical run of set pixels in a raster-order bitmap.
// ----------------------------------------------------------------------------
// The block takes one pixel per clock cycle, row by row and left to right,
// and counts column and row itself from the image_width and image_height
// registers. A per-column memory holds the open run of each column; it is
// read one pixel ahead, so back-to-back pixels never wait, and a write to the
// entry being read is forwarded. After the last pixel of a frame the result
// passes the candidate register and then the result register. Input stalls
// only while a frame's result is ready to leave and the previous result has
// not been taken. No clearing pass is needed after reset.
module longest_vertical_run_finder #(
    parameter int MAX_DIM = lvrf_pkg::MAX_DIM_DEFAULT
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [lvrf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [lvrf_pkg::CFG_W-1:0]       cfg_wdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // Bit 0: pixel.
    input  logic [lvrf_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // Bit 0: found, bits 10:1: line_column, bits 20:11: start_row,
    // bits 30:21: end_row.
    output logic [lvrf_pkg::M_TDATA_W-1:0]   m_tdata
);
    import lvrf_pkg::*;

    localparam int CW = $clog2(MAX_DIM);
    localparam int LW = $clog2(MAX_DIM + 1);

    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    logic             accept;
    logic             stall;
    logic             wr_en;
    logic [CW-1:0]    wr_addr;
    logic [CW:0]      wr_data;
    logic [CW-1:0]    rd_addr;
    logic [CW:0]      entry;
    lvrf_cand_ctrl_t  cand_ctrl;
    logic [CW-1:0]    cand_col;
    logic [CW-1:0]    cand_first;
    logic [CW-1:0]    cand_last;
    logic [LW-1:0]    cand_len;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= SIZE_RESET;
            height_reg <= SIZE_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_IMAGE_WIDTH: begin
                    width_reg <= cfg_wdata;
                end
                REG_IMAGE_HEIGHT: begin
                    height_reg <= cfg_wdata;
                end
                default: begin
                end
            endcase
        end
    end

    assign s_tready = !stall;
    assign accept   = s_tvalid && !stall;

    lvrf_column_store #(
        .DEPTH (MAX_DIM),
        .AW    (CW),
        .DW    (CW + 1)
    ) u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (entry)
    );

    lvrf_run_tracker #(
        .MAX_DIM (MAX_DIM),
        .CW      (CW),
        .LW      (LW)
    ) u_tracker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .image_width  (width_reg),
        .image_height (height_reg),
        .accept       (accept),
        .advance      (!stall),
        .pixel        (s_tdata[0]),
        .entry        (entry),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data),
        .rd_addr      (rd_addr),
        .cand_ctrl    (cand_ctrl),
        .cand_col     (cand_col),
        .cand_first   (cand_first),
        .cand_last    (cand_last),
        .cand_len     (cand_len)
    );

    lvrf_best_select #(
        .MAX_DIM (MAX_DIM),
        .CW      (CW),
        .LW      (LW)
    ) u_select (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cand_ctrl  (cand_ctrl),
        .cand_col   (cand_col),
        .cand_first (cand_first),
        .cand_last  (cand_last),
        .cand_len   (cand_len),
        .stall      (stall),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule
